FILE: rtl/core/poisson_infection_pair_update_defines.svh
// assertion macros for the poisson pair update block
// used by the checker file only
`ifndef POISSON_INFECTION_PAIR_UPDATE_DEFINES_SVH
`define POISSON_INFECTION_PAIR_UPDATE_DEFINES_SVH
// implication checked on every clock outside reset
`define PIPU_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pipu check failed");
// implication with the consequent checked on the next clock
`define PIPU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pipu check failed");
`endif

FILE: rtl/core/pipu_pkg.sv
// shared types and constants for the poisson pair update block
// no dependencies
package pipu_pkg;
   localparam int TOT_W = 35;
   localparam int Q30_W = 32;
   localparam logic [Q30_W-1:0] ONE_Q30 = 32'h4000_0000;
   localparam int TERMS = 16;
   // series term index, 1 to TERMS + 1
   typedef logic [4:0] k_type;
endpackage

FILE: rtl/core/poisson_infection_pair_update.sv
// poisson infection pair update, top level
// depends on pipu_pkg
// One beat in, one beat out, one item at a time. Each pair runs through a
// bit-serial divider (one quotient bit a cycle), then two series evaluations
// of exp(-t), first for e1 and then for the fraction, each of 16 terms (a
// serial multiply, a serial divide by k with its load step, and the series
// and send sequencing states) plus one closing step, then up to 11 powering
// multiplies, the proportion step, the density multiply with its setup and
// the total update. n, the integer part of attacks / density (0 to 11), sets
// how many powering multiplies run; a saturated ratio goes on to the density
// multiply after the divide, and zero density goes to it straight from idle.
// The block is ready again once the result register is loaded; the update
// waits only while an earlier result beat is still stalled.
module poisson_infection_pair_update #(
   parameter int NUM_VECTORS = 8,
   parameter int NUM_HOSTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vector_index[2:0], host_index[5:3], attack_count[37:6],
   // host_density[69:38], zero fill
   input  logic [71:0]  req_tdata,
   // new_round
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // prop_attacked[15:0], hosts_attacked[47:16], vector_attack_total[82:48],
   // vector_attacked_total[117:83], host_attack_total[152:118],
   // host_attacked_total[187:153], zero fill
   output logic [191:0] rsp_tdata
);
   localparam int TW = pipu_pkg::TOT_W;

   // state codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIV  = 4'd1;
   localparam logic [3:0] ST_SER  = 4'd2;
   localparam logic [3:0] ST_MUL  = 4'd3;
   localparam logic [3:0] ST_KDIV = 4'd4;
   localparam logic [3:0] ST_SEND = 4'd5;
   localparam logic [3:0] ST_POW  = 4'd6;
   localparam logic [3:0] ST_PROP = 4'd7;
   localparam logic [3:0] ST_HMUL = 4'd8;
   localparam logic [3:0] ST_UPD  = 4'd9;

   // multiplier users
   localparam logic [1:0] MU_SER  = 2'd0;
   localparam logic [1:0] MU_POW  = 2'd1;
   localparam logic [1:0] MU_HOST = 2'd2;

   localparam logic [5:0] KDIV_LOAD = 6'd32;
   localparam pipu_pkg::k_type K_DONE = 5'(pipu_pkg::TERMS + 1);

   logic [3:0]  state_ff;
   logic [2:0]  vi_ff;
   logic [2:0]  hi_ff;
   logic [31:0] a_ff, d_ff;
   logic        clr_ff;
   logic [61:0] num_ff;    // dividend shifting out msb first
   logic [31:0] rem_ff;
   logic [63:0] x_ff;      // quotient
   logic [5:0]  cnt_ff;
   logic [31:0] t_ff;      // series argument
   logic        pass_ff;   // 0: e1 series, 1: e series
   pipu_pkg::k_type k_ff;
   logic [31:0] term_ff;
   logic [35:0] pos_ff, neg_ff;
   logic [31:0] e1_ff, e_ff;
   logic [3:0]  n_ff;
   // serial multiplier: 32x32, one multiplier bit a cycle
   logic [63:0] prod_ff;
   logic [31:0] mcand_ff, mplier_ff;
   logic [1:0]  muse_ff;
   logic [15:0] p_ff;
   logic [31:0] hosts_ff;
   logic        out_v_ff;
   logic [191:0] out_ff;

   logic [TW-1:0] va_ff [NUM_VECTORS];
   logic [TW-1:0] vd_ff [NUM_VECTORS];
   logic [TW-1:0] ha_ff [NUM_HOSTS];
   logic [TW-1:0] hd_ff [NUM_HOSTS];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   // divider step, multiplier step and series values
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   logic [35:0] diff;
   logic [32:0] ek;
   logic [32:0] rem_k;
   logic [32:0] msum;
   logic [32:0] pnum;
   logic [17:0] pr;
   assign rem_sh  = {rem_ff, num_ff[61]};
   assign rem_sub = rem_sh - {1'b0, d_ff};
   assign rem_k   = {rem_ff, term_ff[31]};
   assign msum    = {1'b0, prod_ff[63:32]} + {1'b0, (mplier_ff[0] ? mcand_ff : 32'd0)};
   assign diff    = (pos_ff >= neg_ff) ? pos_ff - neg_ff : 36'd0;
   assign ek      = (e_ff > pipu_pkg::ONE_Q30) ? {1'b0, pipu_pkg::ONE_Q30} : {1'b0, e_ff};
   assign pnum    = {1'b0, pipu_pkg::ONE_Q30} - ek + 33'd8192;
   assign pr      = 18'(pnum >> 14);

   logic vok, hok;
   assign vok = ({29'd0, vi_ff} < 32'(NUM_VECTORS));
   assign hok = ({29'd0, hi_ff} < 32'(NUM_HOSTS));

   // totals of the addressed vector and host
   logic [TW-1:0] vsel_a, vsel_d, hsel_a, hsel_d;
   always_comb begin
      vsel_a = '0;
      vsel_d = '0;
      hsel_a = '0;
      hsel_d = '0;
      for (int i = 0; i < NUM_VECTORS; i++) begin
         if ({29'd0, vi_ff} == 32'(i)) begin
            vsel_a = va_ff[i];
            vsel_d = vd_ff[i];
         end
      end
      for (int i = 0; i < NUM_HOSTS; i++) begin
         if ({29'd0, hi_ff} == 32'(i)) begin
            hsel_a = ha_ff[i];
            hsel_d = hd_ff[i];
         end
      end
   end

   // updated totals, wrapping at the total width
   logic [TW-1:0] vnew_a, vnew_d, hnew_a, hnew_d;
   assign vnew_a = (clr_ff ? '0 : vsel_a) + TW'(a_ff);
   assign vnew_d = (clr_ff ? '0 : vsel_d) + TW'(hosts_ff);
   assign hnew_a = (clr_ff ? '0 : hsel_a) + TW'(a_ff);
   assign hnew_d = (clr_ff ? '0 : hsel_d) + TW'(hosts_ff);

   logic load_out;
   assign load_out = (state_ff == ST_UPD) && (!out_v_ff || rsp_tready);

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (load_out) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NUM_VECTORS; i++) begin
            va_ff[i] <= '0;
            vd_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_HOSTS; i++) begin
            ha_ff[i] <= '0;
            hd_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  vi_ff  <= req_tdata[2:0];
                  hi_ff  <= req_tdata[5:3];
                  a_ff   <= req_tdata[37:6];
                  d_ff   <= req_tdata[69:38];
                  clr_ff <= req_tuser;
                  num_ff <= {req_tdata[37:6], 30'd0};
                  rem_ff <= '0;
                  x_ff   <= '0;
                  cnt_ff <= 6'd61;
                  p_ff   <= '0;
                  state_ff <= (req_tdata[69:38] == 32'd0) ? ST_HMUL : ST_DIV;
                  muse_ff <= MU_HOST;
               end
            end
            ST_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (!rem_sub[32]) begin
                  rem_ff <= rem_sub[31:0];
                  x_ff   <= {x_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[31:0];
                  x_ff   <= {x_ff[62:0], 1'b0};
               end
               num_ff <= {num_ff[60:0], 1'b0};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  state_ff <= ST_SER;
                  pass_ff  <= 1'b0;
                  t_ff     <= pipu_pkg::ONE_Q30;
                  term_ff  <= pipu_pkg::ONE_Q30;
                  pos_ff   <= 36'(pipu_pkg::ONE_Q30);
                  neg_ff   <= '0;
                  k_ff     <= 5'd1;
               end
            end
            ST_SER: begin
               if (x_ff >= 64'd12 << 30) begin
                  p_ff <= 16'hFFFF;
                  muse_ff <= MU_HOST;
                  state_ff <= ST_HMUL;
               end else if (k_ff == K_DONE) begin
                  if (!pass_ff) begin
                     e1_ff   <= diff[31:0];
                     pass_ff <= 1'b1;
                     t_ff    <= {2'b0, x_ff[29:0]};
                     term_ff <= pipu_pkg::ONE_Q30;
                     pos_ff  <= 36'(pipu_pkg::ONE_Q30);
                     neg_ff  <= '0;
                     k_ff    <= 5'd1;
                  end else begin
                     e_ff <= diff[31:0];
                     n_ff <= x_ff[33:30];
                     state_ff <= ST_POW;
                  end
               end else begin
                  prod_ff   <= '0;
                  mcand_ff  <= term_ff;
                  mplier_ff <= t_ff;
                  cnt_ff    <= 6'd31;
                  muse_ff   <= MU_SER;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               // shift-add, lsb of multiplier first
               prod_ff   <= {msum, prod_ff[31:1]};
               mplier_ff <= mplier_ff >> 1;
               if (cnt_ff != 6'd0) begin
                  cnt_ff <= cnt_ff - 6'd1;
               end else if (muse_ff == MU_SER) begin
                  cnt_ff   <= KDIV_LOAD;
                  state_ff <= ST_KDIV;
               end else begin
                  state_ff <= ST_SEND;
               end
            end
            ST_KDIV: begin
               // term = (prod >> 30) / k, one bit per cycle after a load step
               if (cnt_ff == KDIV_LOAD) begin
                  term_ff <= prod_ff[61:30];
                  rem_ff  <= '0;
                  cnt_ff  <= 6'd31;
               end else begin
                  if (rem_k >= {28'd0, k_ff}) begin
                     rem_ff  <= 32'(rem_k - {28'd0, k_ff});
                     term_ff <= {term_ff[30:0], 1'b1};
                  end else begin
                     rem_ff  <= rem_k[31:0];
                     term_ff <= {term_ff[30:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 6'd1;
                  if (cnt_ff == 6'd0) begin
                     state_ff <= ST_SEND;
                  end
               end
            end
            ST_SEND: begin
               if (muse_ff == MU_SER) begin
                  if (k_ff[0]) begin
                     neg_ff <= neg_ff + 36'(term_ff);
                  end else begin
                     pos_ff <= pos_ff + 36'(term_ff);
                  end
                  k_ff <= k_ff + 5'd1;
                  state_ff <= ST_SER;
               end else if (muse_ff == MU_POW) begin
                  e_ff <= prod_ff[61:30];
                  n_ff <= n_ff - 4'd1;
                  state_ff <= ST_POW;
               end else begin
                  hosts_ff <= prod_ff[47:16];
                  state_ff <= ST_UPD;
               end
            end
            ST_POW: begin
               if (n_ff == 4'd0) begin
                  state_ff <= ST_PROP;
               end else begin
                  prod_ff   <= '0;
                  mcand_ff  <= e1_ff;
                  mplier_ff <= e_ff;
                  cnt_ff    <= 6'd31;
                  muse_ff   <= MU_POW;
                  state_ff  <= ST_MUL;
               end
            end
            ST_PROP: begin
               p_ff <= (pr > 18'd65535) ? 16'hFFFF : pr[15:0];
               muse_ff <= MU_HOST;
               state_ff <= ST_HMUL;
            end
            ST_HMUL: begin
               prod_ff   <= '0;
               mcand_ff  <= d_ff;
               mplier_ff <= {16'd0, p_ff};
               cnt_ff    <= 6'd31;
               muse_ff   <= MU_HOST;
               state_ff  <= ST_MUL;
            end
            ST_UPD: begin
               if (load_out) begin
                  // addressed entries take the new totals, the rest clear on a new round
                  for (int i = 0; i < NUM_VECTORS; i++) begin
                     if ({29'd0, vi_ff} == 32'(i)) begin
                        va_ff[i] <= vnew_a;
                        vd_ff[i] <= vnew_d;
                     end else if (clr_ff) begin
                        va_ff[i] <= '0;
                        vd_ff[i] <= '0;
                     end
                  end
                  for (int i = 0; i < NUM_HOSTS; i++) begin
                     if ({29'd0, hi_ff} == 32'(i)) begin
                        ha_ff[i] <= hnew_a;
                        hd_ff[i] <= hnew_d;
                     end else if (clr_ff) begin
                        ha_ff[i] <= '0;
                        hd_ff[i] <= '0;
                     end
                  end
                  out_ff <= {4'd0,
                             (hok ? hnew_d : '0), (hok ? hnew_a : '0),
                             (vok ? vnew_d : '0), (vok ? vnew_a : '0),
                             hosts_ff, p_ff};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/core/pipu_checker.sv
// port-level checks for the poisson pair update block
// depends on poisson_infection_pair_update_defines.svh
`include "poisson_infection_pair_update_defines.svh"
module pipu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata
);
   // result beat holds while stalled
   `PIPU_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // the block is busy right after taking a beat
   `PIPU_ASSERT_NEXT(busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // fill bits stay zero
   `PIPU_ASSERT(fill_zero, clock, reset, rsp_tvalid, rsp_tdata[191:188] == 4'd0)
endmodule

bind poisson_infection_pair_update pipu_checker u_pipu_checker (.*);
